// ----- design/contiguous_slot_run_grouper_defines.svh -----
// Assertion macros used by the checker file.
`ifndef CONTIGUOUS_SLOT_RUN_GROUPER_DEFINES_SVH
`define CONTIGUOUS_SLOT_RUN_GROUPER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CSRG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CSRG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/csrg_pkg.sv -----
package csrg_pkg;

	// Field widths.
	localparam int BS_W   = 17;
	localparam int SLOT_W = 31;
	localparam int IDX_W  = 16;
	localparam int LEN_W  = 17;

	// Block size register reset value and saturation limit.
	localparam logic [BS_W-1:0] BS_RESET = 17'd128;
	localparam logic [BS_W-1:0] BS_MAX   = 17'h10000;

	// Longest run before it is forcibly closed.
	localparam logic [LEN_W-1:0] RUN_MAX = 17'h10000;

	// Default list length at which the position counter wraps.
	localparam int MAX_LIST_LEN_DEF = 65536;

	// Depth of the queue between front and back.
	localparam int FIFO_DEPTH = 4;

	// Remainder unit: dividend padded to 32 bits, four bits per cycle.
	localparam int REM_DIVIDEND_W = 32;
	localparam int REM_BITS_PER_CYC = 4;
	localparam int REM_CYCLES = REM_DIVIDEND_W / REM_BITS_PER_CYC;

	// One input beat after classification.
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              skip;
		logic              eol;
	} csrg_item_t;

	// One result record.
	typedef struct packed {
		logic [IDX_W-1:0]  source_index;
		logic [SLOT_W-1:0] start_slot;
		logic [LEN_W-1:0]  run_length;
		logic              last_record;
	} csrg_rec_t;

	// Status of the remainder unit as seen by the back end.
	typedef struct packed {
		logic            busy;
		logic            done;
		logic [BS_W-1:0] rem;
	} csrg_rem_stat_t;

endpackage

// ----- design/csrg_front.sv -----
module csrg_front
	import csrg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       slot,
	input  logic              end_of_list,
	input  logic              pop,
	output logic              head_valid,
	output csrg_item_t        head
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	csrg_item_t       queue_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             push;
	csrg_item_t       item;

	// Classify the incoming beat: the sign bit marks a skipped entry.
	always_comb begin
		item.slot = slot[SLOT_W-1:0];
		item.skip = slot[31];
		item.eol  = end_of_list;
	end

	assign in_ready   = (count_q != (PTR_W+1)'(FIFO_DEPTH));
	assign push       = in_valid && in_ready;
	assign head_valid = (count_q != '0);
	assign head       = queue_q[rd_ptr_q];

	// Queue storage; entries need no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= item;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (PTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- design/csrg_rem.sv -----
module csrg_rem
	import csrg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SLOT_W-1:0] dividend,
	input  logic [BS_W-1:0]   divisor,
	output csrg_rem_stat_t    stat
);

	localparam int CNT_W = $clog2(REM_CYCLES);

	logic                      busy_q;
	logic                      done_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [REM_DIVIDEND_W-1:0] shift_q;
	logic [BS_W-1:0]           rem_q;
	logic [BS_W-1:0]           rem_next;

	// Restoring remainder steps, several dividend bits per cycle.
	always_comb begin
		logic [BS_W:0] t;
		rem_next = rem_q;
		for (int i = 0; i < REM_BITS_PER_CYC; i++) begin
			t = {rem_next, shift_q[REM_DIVIDEND_W-1-i]};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
			end
			rem_next = t[BS_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.rem  = rem_q;

	// Iteration control and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			shift_q <= '0;
			rem_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				cnt_q   <= '0;
				shift_q <= REM_DIVIDEND_W'(dividend);
				rem_q   <= '0;
			end else if (busy_q) begin
				rem_q   <= rem_next;
				shift_q <= shift_q << REM_BITS_PER_CYC;
				cnt_q   <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(REM_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- design/csrg_back.sv -----
module csrg_back
	import csrg_pkg::*;
#(
	parameter int MAX_LIST_LEN = MAX_LIST_LEN_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [BS_W-1:0] bs,
	input  logic            head_valid,
	input  csrg_item_t      head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output csrg_rec_t       out_rec
);

	// The position wraps at the list length limit or at the index width, whichever is smaller.
	localparam int POS_LIM = (MAX_LIST_LEN < (1 << IDX_W)) ? MAX_LIST_LEN : (1 << IDX_W);
	localparam int POS_W   = $clog2(POS_LIM);

	typedef enum logic {
		B_ITEM,
		B_END
	} back_state_t;

	back_state_t       state_q;
	logic              run_open_q;
	logic [SLOT_W-1:0] prev_q;
	logic [BS_W-1:0]   off_q;
	logic [IDX_W-1:0]  rsi_q;
	logic [SLOT_W-1:0] rss_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [POS_W-1:0]  pos_q;
	logic              out_valid_q;
	csrg_rec_t         out_rec_q;

	csrg_rem_stat_t    rem_stat;
	logic              rem_start;
	logic [31:0]       pos_wide;
	logic [31:0]       prev_inc;
	logic              seq;
	logic              in_block;
	logic              extend;
	logic              close;
	logic              out_free;
	logic              go;
	logic              end_go;
	csrg_rec_t         item_rec;
	csrg_rec_t         end_rec;

	// Block offset of a newly opened run's first slot.
	csrg_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (head.slot),
		.divisor  (bs),
		.stat     (rem_stat)
	);

	assign pos_wide = 32'(pos_q);
	assign prev_inc = {1'b0, prev_q} + 32'd1;

	// Run continuation test for the head beat.
	assign seq      = (prev_inc == {1'b0, head.slot});
	assign in_block = ((off_q + BS_W'(1)) != bs);
	assign extend   = !head.skip && run_open_q && (cnt_q != RUN_MAX) && seq && in_block;
	assign close    = !extend && run_open_q;

	assign out_free  = !out_valid_q || out_ready;
	assign go        = (state_q == B_ITEM) && head_valid && !rem_stat.busy
	                   && !rem_stat.done && out_free;
	assign end_go    = (state_q == B_END) && out_free;
	assign pop       = go;
	assign rem_start = go && !extend && !head.skip && !head.eol;

	// Record for the end of a list when the head beat emits only one record.
	always_comb begin
		if (extend) begin
			end_rec = '{source_index: rsi_q, start_slot: rss_q,
			            run_length: cnt_q + LEN_W'(1), last_record: 1'b1};
		end else if (!head.skip) begin
			end_rec = '{source_index: pos_wide[IDX_W-1:0], start_slot: head.slot,
			            run_length: LEN_W'(1), last_record: 1'b1};
		end else begin
			end_rec = '{source_index: '0, start_slot: '0,
			            run_length: '0, last_record: 1'b1};
		end
	end

	// The closing record of an open run goes out first.
	always_comb begin
		if (close) begin
			item_rec = '{source_index: rsi_q, start_slot: rss_q,
			             run_length: cnt_q, last_record: 1'b0};
		end else begin
			item_rec = end_rec;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rec   = out_rec_q;

	// Run state, list position, output register and sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_ITEM;
			run_open_q  <= 1'b0;
			prev_q      <= '0;
			off_q       <= '0;
			rsi_q       <= '0;
			rss_q       <= '0;
			cnt_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			out_rec_q   <= '0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (rem_stat.done) begin
				off_q <= rem_stat.rem;
			end
			unique case (state_q)
				B_ITEM: begin
					if (go) begin
						if (close || head.eol) begin
							out_valid_q <= 1'b1;
							out_rec_q   <= item_rec;
						end
						if (extend) begin
							cnt_q  <= cnt_q + LEN_W'(1);
							prev_q <= head.slot;
							off_q  <= off_q + BS_W'(1);
						end else if (!head.skip) begin
							run_open_q <= 1'b1;
							rsi_q      <= pos_wide[IDX_W-1:0];
							rss_q      <= head.slot;
							cnt_q      <= LEN_W'(1);
							prev_q     <= head.slot;
						end else begin
							run_open_q <= 1'b0;
						end
						if (head.eol) begin
							pos_q <= '0;
							if (close) begin
								state_q <= B_END;
							end else begin
								run_open_q <= 1'b0;
							end
						end else if (pos_q == POS_W'(POS_LIM - 1)) begin
							pos_q <= '0;
						end else begin
							pos_q <= pos_q + POS_W'(1);
						end
					end
				end
				B_END: begin
					if (end_go) begin
						out_valid_q <= 1'b1;
						if (run_open_q) begin
							out_rec_q <= '{source_index: rsi_q, start_slot: rss_q,
							               run_length: cnt_q, last_record: 1'b1};
						end else begin
							out_rec_q <= '{source_index: '0, start_slot: '0,
							               run_length: '0, last_record: 1'b1};
						end
						run_open_q <= 1'b0;
						state_q    <= B_ITEM;
					end
				end
				default: state_q <= B_ITEM;
			endcase
		end
	end

endmodule

// ----- design/contiguous_slot_run_grouper.sv -----
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------------------
// input    | in_valid / in_ready  | slot[31:0], end_of_list
// output   | out_valid / out_ready| source_index, start_slot, run_length, last_record
// config   | cfg_wr_en            | cfg_wr_data[16:0] (slots per block)
//
// A beat that extends a run or is skipped needs no remainder computation.
// A beat that opens a run (not at list end) holds the back end while the block offset
// of its slot is computed by a remainder unit that retires four bits per cycle.
// A beat that closes a run and ends the list emits two records: the closing one, then the last.
// A four-entry queue keeps accepting beats until full while the back end works or the
// output stalls; reset clears the queue, run state and the output register.
module contiguous_slot_run_grouper
	import csrg_pkg::*;
#(
	parameter int MAX_LIST_LEN = MAX_LIST_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [BS_W-1:0]   cfg_wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       slot,
	input  logic              end_of_list,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [IDX_W-1:0]  source_index,
	output logic [SLOT_W-1:0] start_slot,
	output logic [LEN_W-1:0]  run_length,
	output logic              last_record
);

	logic [BS_W-1:0] bs_q;
	logic            head_valid;
	csrg_item_t      head;
	logic            pop;
	csrg_rec_t       out_rec;

	// Block size register; zero reads as one, large values saturate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q <= BS_RESET;
		end else if (cfg_wr_en) begin
			if (cfg_wr_data == '0) begin
				bs_q <= BS_W'(1);
			end else if (cfg_wr_data > BS_MAX) begin
				bs_q <= BS_MAX;
			end else begin
				bs_q <= cfg_wr_data;
			end
		end
	end

	// Front end: accept and classify beats into the queue.
	csrg_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.slot        (slot),
		.end_of_list (end_of_list),
		.pop         (pop),
		.head_valid  (head_valid),
		.head        (head)
	);

	// Back end: run tracking and record output.
	csrg_back #(
		.MAX_LIST_LEN (MAX_LIST_LEN)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.bs         (bs_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_rec    (out_rec)
	);

	assign source_index = out_rec.source_index;
	assign start_slot   = out_rec.start_slot;
	assign run_length   = out_rec.run_length;
	assign last_record  = out_rec.last_record;

endmodule

// ----- design/csrg_checker.sv -----
`include "contiguous_slot_run_grouper_defines.svh"

module csrg_checker
	import csrg_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [IDX_W-1:0]  source_index,
	input logic [SLOT_W-1:0] start_slot,
	input logic [LEN_W-1:0]  run_length,
	input logic              last_record
);

	// A stalled record holds until it is taken.
	`CSRG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(run_length) && $stable(start_slot)
		&& $stable(source_index) && $stable(last_record),
		"output record changed while stalled")

	// A record that closes a run mid-list always holds at least one entry.
	`CSRG_ASSERT_NOW(a_close_nonempty, out_valid && !last_record, run_length != '0,
		"empty record without end flag")

	// An empty record is the list-end marker and carries zero fields.
	`CSRG_ASSERT_NOW(a_empty_rec, out_valid && run_length == '0,
		last_record && source_index == '0 && start_slot == '0, "malformed empty record")

	// No run grows past the run length limit.
	`CSRG_ASSERT_NOW(a_len_limit, out_valid, run_length <= RUN_MAX, "run length above limit")

endmodule

bind contiguous_slot_run_grouper csrg_checker u_csrg_checker (.*);
